[sv/grb_pkg.sv]
// Package for the group reversal buffer: sizes, item types and sequencer states.
`default_nettype none
package grb_pkg;

   localparam int MaxGroup = 16;
   localparam int AddrW    = $clog2(MaxGroup);
   localparam int CntW     = $clog2(MaxGroup + 1);
   localparam int DataW    = 32;
   localparam int CsrW     = 5;

   typedef struct packed {
      logic signed [DataW-1:0] value;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0] out_value;
      logic                    group_end;
      logic                    list_end;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage
`default_nettype wire

[sv/grb_ram.sv]
// Generic single-clock RAM, one write port and one read port with registered read.
`default_nettype none
module grb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[sv/group_reversal_buffer_unit.sv]
// Top level of the group reversal buffer: stack memory, drain sequencer and output register.
// Values are pushed into a 16-entry stack RAM, one item per cycle while no group is being
// emitted. When a group of group_size values is complete, or an item with last set
// arrives, the stack is drained newest first, one RAM read per result; each result
// is read from the RAM and then loaded into the output register, and no new item is
// taken until the whole group has been read out. The output register lets the next
// item enter while the final result still waits.
// group_size 0 and 1 both pass values through; values above 16 act as 16.
`default_nettype none
module group_reversal_buffer_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire grb_pkg::req_type        req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output grb_pkg::rsp_type             rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [grb_pkg::CsrW-1:0] csr_data
);
   import grb_pkg::*;

   state_type             state_ff, state_in;
   logic [CsrW-1:0]       size_ff;
   logic [CntW-1:0]       fill_ff, fill_in;
   logic [CntW-1:0]       rem_ff, rem_in;
   logic                  last_ff, last_in;
   logic                  pend_ff, pend_in;
   logic                  pend_final_ff, pend_final_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   logic [CntW-1:0]       k_eff;
   logic [CntW-1:0]       push_count;
   logic                  req_fire;
   logic                  rd_issue;
   logic [AddrW-1:0]      rd_addr;
   logic [DataW-1:0]      rd_data;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (size_ff == '0) begin
         k_eff = CntW'(1);
      end else if (CntW'(size_ff) > CntW'(MaxGroup)) begin
         k_eff = CntW'(MaxGroup);
      end else begin
         k_eff = CntW'(size_ff);
      end
   end

   assign push_count = fill_ff + CntW'(1);
   assign req_fire   = req_valid && req_ready;
   assign rd_addr    = AddrW'(rem_ff - CntW'(1));

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rem_in        = rem_ff;
      last_in       = last_ff;
      req_ready     = 1'b0;
      rd_issue      = 1'b0;
      pend_in       = 1'b0;
      pend_final_in = pend_final_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (push_count >= k_eff || req_data.last) begin
                  rem_in   = push_count;
                  last_in  = req_data.last;
                  fill_in  = '0;
                  state_in = ST_DRAIN;
               end else begin
                  fill_in = push_count;
               end
            end
         end
         ST_DRAIN: begin
            if (!pend_ff && (!rsp_valid_ff || rsp_ready)) begin
               rd_issue      = 1'b1;
               pend_in       = 1'b1;
               pend_final_in = (rem_ff == CntW'(1));
               rem_in        = rem_ff - CntW'(1);
               if (rem_ff == CntW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= CsrW'(1);
         fill_ff      <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      pend_final_ff <= pend_final_in;
      if (pend_ff) begin
         rsp_data_ff.out_value <= rd_data;
         rsp_data_ff.group_end <= pend_final_ff;
         rsp_data_ff.list_end  <= pend_final_ff && last_ff;
      end
   end

   grb_ram #(
      .WIDTH (DataW),
      .DEPTH (MaxGroup)
   ) u_stack (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (AddrW'(fill_ff)),
      .wr_data (req_data.value),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

[verif/group_reversal_buffer_unit_test.sv]
// Self-checking testbench for the group reversal buffer: directed, back-pressure and random lists.
`default_nettype none
module group_reversal_buffer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import grb_pkg::*;

   localparam int DrainCycles = 2 * MaxGroup + 16;
   localparam int RandomItems = 340;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CsrW-1:0]  csr_data;

   rsp_type          pending_rsp[$];
   logic [DataW-1:0] stack_model[MaxGroup];
   int               stack_depth;
   logic [CsrW-1:0]  group_size_model;

   int items_sent;
   int results_checked;
   int mismatches;
   int csr_writes;
   int hold_request;
   int stall_left;
   bit send_gaps;
   bit rsp_stalls;

   group_reversal_buffer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 15) return $urandom_range(1, 3);
      if (pick < 19) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int effective_size();
      int k;
      k = int'(group_size_model);
      if (k == 0) k = 1;
      if (k > MaxGroup) k = MaxGroup;
      return k;
   endfunction

   function automatic void predict_reversal(req_type item);
      rsp_type want;
      if (stack_depth < MaxGroup) begin
         stack_model[stack_depth] = item.value;
         stack_depth++;
      end
      if (stack_depth < effective_size() && !item.last) return;
      for (int i = stack_depth - 1; i >= 0; i--) begin
         want.out_value = stack_model[i];
         want.group_end = (i == 0);
         want.list_end  = (i == 0) && item.last;
         pending_rsp.push_back(want);
      end
      stack_depth = 0;
   endfunction

   function automatic logic [DataW-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return DataW'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_stalls && $urandom_range(0, 5) == 0) stall_left = idle_length();
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected item value=%0d group_end=%b list_end=%b", $realtime,
                        rsp_data.out_value, rsp_data.group_end, rsp_data.list_end);
         end else begin
            want = pending_rsp.pop_front();
            if (want.out_value !== rsp_data.out_value || want.group_end !== rsp_data.group_end
                || want.list_end !== rsp_data.list_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected %0d/%b/%b, got %0d/%b/%b",
                           $realtime, want.out_value, want.group_end, want.list_end,
                           rsp_data.out_value, rsp_data.group_end, rsp_data.list_end);
            end
         end
      end
   end

   task automatic send_item(input logic [DataW-1:0] value, input logic last);
      req_type item;
      int      gap;
      item.value = value;
      item.last  = last;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_reversal(item);
      items_sent++;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         gap = idle_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_group_size(input logic [CsrW-1:0] size);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      group_size_model = size;
      csr_writes++;
   endtask

   task automatic send_list(input int length);
      for (int i = 0; i < length; i++) send_item(random_value(), i == length - 1);
   endtask

   task automatic test_reset_default();
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b1);
   endtask

   task automatic test_pass_through();
      write_group_size(5'd0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h0000_0000, 1'b1);
   endtask

   task automatic test_group_reverse();
      write_group_size(5'd4);
      for (int i = 1; i <= 6; i++) send_item(DataW'(i), i == 6);
   endtask

   task automatic test_shrink_mid_group();
      write_group_size(5'd8);
      for (int i = 0; i < 5; i++) send_item(DataW'(100 + i), 1'b0);
      write_group_size(5'd3);
      send_item(32'h8000_0001, 1'b1);
   endtask

   task automatic test_list_restart();
      write_group_size(5'd5);
      send_item(32'h0000_0011, 1'b0);
      send_item(32'h0000_0022, 1'b1);
      send_item(32'h0000_0033, 1'b1);
   endtask

   task automatic test_input_backpressure();
      write_group_size(5'd4);
      send_gaps = 1'b0;
      rsp_stalls = 1'b0;
      hold_request = 300;
      send_list(40);
   endtask

   task automatic test_random_lists();
      logic [CsrW-1:0] fixed_sizes[13];
      int              sent;
      int              phase;
      int              phase_end;
      int              k;
      fixed_sizes = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd5, 5'd31, 5'd7, 5'd8, 5'd17, 5'd13,
                      5'd15, 5'd4};
      sent = 0;
      phase = 0;
      while (sent < RandomItems) begin
         if (phase < 13) write_group_size(fixed_sizes[phase]);
         else write_group_size(CsrW'($urandom_range(0, 31)));
         phase++;
         send_gaps  = (phase % 4 != 0) && ($urandom_range(0, 2) != 0);
         rsp_stalls = (phase % 4 != 0) && ($urandom_range(0, 2) != 0);
         k = effective_size();
         phase_end = sent + $urandom_range(20, 40);
         while (sent < phase_end) begin
            if ($urandom_range(0, 4) == 0) k = $urandom_range(1, 60);
            else k = $urandom_range(1, 3 * effective_size() + 2);
            send_list(k);
            sent += k;
         end
         if ($urandom_range(0, 9) < 3) begin
            k = $urandom_range(1, 5);
            for (int i = 0; i < k; i++) send_item(random_value(), 1'b0);
            sent += k;
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      stack_depth      = 0;
      group_size_model = 5'd1;
      items_sent       = 0;
      results_checked  = 0;
      mismatches       = 0;
      csr_writes       = 0;
      send_gaps        = 1'b0;
      rsp_stalls       = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_default();
      test_pass_through();
      test_group_reverse();
      test_shrink_mid_group();
      test_list_restart();
      test_input_backpressure();
      test_random_lists();

      wait_drained();
      $display("Covered %0d items and %0d results over %0d group size writes; %0d mismatches",
               items_sent, results_checked, csr_writes, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
sv/grb_pkg.sv
sv/grb_ram.sv
sv/group_reversal_buffer_unit.sv
verif/group_reversal_buffer_unit_test.sv
